// ----- design/packed_trie_walk_step_assert.svh -----
// Assertion macros used by the checker file of the trie walker.
`ifndef PACKED_TRIE_WALK_STEP_ASSERT_SVH
`define PACKED_TRIE_WALK_STEP_ASSERT_SVH

// Overlapping implication, disabled while reset is held.
`define PTW_ASSERT_NOW(label, ck, rn, a, b) \
    label: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PTW_ASSERT_NEXT(label, ck, rn, a, b) \
    label: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ----- design/ptw_pkg.sv -----
// Package with types and constants of the packed trie walker.
package ptw_pkg;

    localparam int TRIE_BYTES  = 4096;
    localparam int TRIE_AW     = 12;
    localparam int ORDER_DEPTH = 256;
    localparam int ORDER_AW    = 8;
    localparam int NODE_BITS   = 16;
    localparam int BYTE_ADDR_W = 21;
    localparam int PROBE_W     = 9;
    localparam int FIELD_W     = 32;
    localparam int ACC_W       = 40;

    localparam logic [1:0] ACT_LOAD_TRIE  = 2'd0;
    localparam logic [1:0] ACT_LOAD_ORDER = 2'd1;
    localparam logic [1:0] ACT_RESET_WALK = 2'd2;
    localparam logic [1:0] ACT_ADVANCE    = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PARTIAL = 2'd1;
    localparam logic [1:0] ST_MISS    = 2'd2;

    localparam logic [2:0] REG_RECORD_BITS  = 3'd0;
    localparam logic [2:0] REG_CODE_BITS    = 3'd1;
    localparam logic [2:0] REG_SIBLING_BITS = 3'd2;
    localparam logic [2:0] REG_CHILD_OFFSET = 3'd3;
    localparam logic [2:0] REG_CHILD_BITS   = 3'd4;
    localparam logic [2:0] REG_CODE_COUNT   = 3'd5;
    localparam logic [2:0] REG_TRIE_LENGTH  = 3'd6;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_MUL,
        FR_ADDR,
        FR_ISSUE,
        FR_CAPT,
        FR_FIN
    } fr_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORD_RD,
        S_SORD_CAP,
        S_CHILD_REQ,
        S_CHILD_WAIT,
        S_PROBE,
        S_CODE_REQ,
        S_CODE_WAIT,
        S_CORD_RD,
        S_CORD_CAP,
        S_SIB_REQ,
        S_SIB_WAIT,
        S_OUT
    } walk_state_t;

    typedef struct packed {
        logic                 start;
        logic [NODE_BITS-1:0] node;
        logic [5:0]           pos;
        logic [4:0]           width;
    } fr_req_t;

    typedef struct packed {
        logic               done;
        logic [FIELD_W-1:0] value;
    } fr_rsp_t;

endpackage

// ----- design/ptw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/ptw_field_reader.sv -----
// Bit-field reader: extracts an MSB-first field from the packed trie bytes.
module ptw_field_reader (
    input  logic              clk,
    input  logic              rst_n,
    input  ptw_pkg::fr_req_t  req,
    output ptw_pkg::fr_rsp_t  rsp,
    input  logic [6:0]        record_bits,
    input  logic [12:0]       trie_length,
    input  logic              wr_en,
    input  logic [11:0]       wr_addr,
    input  logic [7:0]        wr_data
);
    import ptw_pkg::*;

    fr_state_t state_reg, state_next;

    logic [22:0]            prod_reg;
    logic [5:0]             pos_reg;
    logic [4:0]             width_reg;
    logic [BYTE_ADDR_W-1:0] addr_reg;
    logic [2:0]             offs_reg;
    logic [2:0]             nbytes_reg;
    logic [3:0]             shift_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic                   first_reg;
    logic                   inrange_reg;
    logic [FIELD_W-1:0]     value_reg;

    logic [TRIE_AW-1:0]     ram_raddr;
    logic [7:0]             ram_rdata;
    logic [23:0]            bit_pos;
    logic [6:0]             total;
    logic [6:0]             nsum;
    logic [2:0]             nbytes;
    logic [6:0]             shift_w;
    logic [7:0]             byte_in;
    logic [ACC_W-1:0]       acc_shifted;

    ptw_ram #(.WIDTH(8), .DEPTH(TRIE_BYTES)) u_trie_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign bit_pos = {1'b0, prod_reg} + {18'd0, pos_reg};
    assign total   = {4'd0, bit_pos[2:0]} + {2'd0, width_reg};
    assign nsum    = (total + 7'd7) >> 3;
    assign nbytes  = (nsum[2:0] == 3'd0) ? 3'd1 : nsum[2:0];
    assign shift_w = {1'b0, nbytes, 3'd0} - total;
    assign acc_shifted = acc_reg >> shift_reg;

    always_comb
    begin
        byte_in = inrange_reg ? ram_rdata : 8'd0;
        if (first_reg)
        begin
            byte_in = byte_in & (8'hFF >> offs_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:  if (req.start) state_next = FR_MUL;
            FR_MUL:   state_next = FR_ADDR;
            FR_ADDR:  state_next = FR_ISSUE;
            FR_ISSUE: state_next = FR_CAPT;
            FR_CAPT:  state_next = (nbytes_reg == 3'd1) ? FR_FIN : FR_ISSUE;
            FR_FIN:   state_next = FR_IDLE;
            default:  state_next = FR_IDLE;
        endcase
    end

    always_comb
    begin
        ram_raddr = addr_reg[TRIE_AW-1:0];
        rsp.done  = (state_reg == FR_FIN);
        rsp.value = value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            FR_IDLE:
            begin
                if (req.start)
                begin
                    prod_reg  <= 23'(req.node) * 23'(record_bits);
                    pos_reg   <= req.pos;
                    width_reg <= req.width;
                end
            end
            FR_MUL:
            begin
                addr_reg   <= bit_pos[23:3];
                offs_reg   <= bit_pos[2:0];
                nbytes_reg <= nbytes;
                shift_reg  <= shift_w[3:0];
                acc_reg    <= '0;
                first_reg  <= 1'b1;
            end
            FR_ISSUE:
            begin
                inrange_reg <= (addr_reg < {8'd0, trie_length})
                               && (addr_reg[BYTE_ADDR_W-1:TRIE_AW] == '0);
            end
            FR_CAPT:
            begin
                acc_reg    <= {acc_reg[ACC_W-9:0], byte_in};
                first_reg  <= 1'b0;
                addr_reg   <= addr_reg + 1'b1;
                nbytes_reg <= nbytes_reg - 1'b1;
            end
            FR_FIN:
            begin
                value_reg <= acc_shifted[FIELD_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // value_reg loads during FR_FIN and holds the field from the cycle after done.
endmodule

// ----- design/packed_trie_walk_step.sv -----
// Top level of the packed trie walker: sequencer, order table and ports.
// One beat in, one beat out. A load or walk reset offers its result in the cycle
// after it is taken, and the next beat is taken only after that result leaves. An
// advance runs a sequencer over one shared bit-field reader; each field read goes
// through a request, a multiply for the record's bit address, an address step, an
// issue and a capture per byte through a registered-read port, a finish step and a
// handoff step. Stepping over one sibling takes a code read, an order table read
// and capture, a sibling read and a probe step. An advance that steps over P
// siblings makes P such steps; ending on a record's code adds one more code read.
// s_tready is high only while no beat is in flight.
module packed_trie_walk_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], load_addr[13:2], load_data[21:14], symbol[29:22], zero pad
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], node_index[17:2], prev_node[33:18], zero pad
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);
    import ptw_pkg::*;

    walk_state_t state_reg, state_next;

    logic [6:0]  record_bits_reg;
    logic [4:0]  code_bits_reg;
    logic [4:0]  sibling_bits_reg;
    logic [5:0]  child_offset_reg;
    logic [4:0]  child_bits_reg;
    logic [7:0]  code_count_reg;
    logic [12:0] trie_length_reg;

    logic [NODE_BITS-1:0] cur_reg;
    logic [NODE_BITS-1:0] prev_reg;
    logic                 started_reg;
    logic [NODE_BITS-1:0] idx_reg;
    logic [FIELD_W-1:0]   jump_reg;
    logic [PROBE_W-1:0]   probes_reg;
    logic [7:0]           scan_reg;
    logic [7:0]           sord_reg;
    logic [7:0]           code_reg;
    logic [1:0]           status_reg;

    logic [1:0]  in_action;
    logic [11:0] in_addr;
    logic [7:0]  in_data;
    logic [7:0]  in_char;
    logic        accept;

    fr_req_t fr_req;
    fr_rsp_t fr_rsp;
    logic    fr_done_q;
    logic [FIELD_W-1:0] fr_value;

    logic                order_we;
    logic [ORDER_AW-1:0] order_raddr;
    logic [7:0]          order_rdata;
    logic                trie_we;

    logic code_bad;
    logic code_hit;

    assign in_action = s_tdata[1:0];
    assign in_addr   = s_tdata[13:2];
    assign in_data   = s_tdata[21:14];
    assign in_char   = s_tdata[29:22];
    assign accept    = s_tvalid && s_tready;

    assign trie_we  = accept && (in_action == ACT_LOAD_TRIE);
    assign order_we = accept && (in_action == ACT_LOAD_ORDER)
                      && (in_addr[11:ORDER_AW] == '0);

    ptw_field_reader u_reader (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (fr_req),
        .rsp         (fr_rsp),
        .record_bits (record_bits_reg),
        .trie_length (trie_length_reg),
        .wr_en       (trie_we),
        .wr_addr     (in_addr),
        .wr_data     (in_data)
    );

    ptw_ram #(.WIDTH(8), .DEPTH(ORDER_DEPTH)) u_order_ram (
        .clk   (clk),
        .we    (order_we),
        .waddr (in_addr[ORDER_AW-1:0]),
        .wdata (in_data),
        .raddr (order_raddr),
        .rdata (order_rdata)
    );

    // The reader's value settles in the cycle after its done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_done_q <= 1'b0;
        end
        else
        begin
            fr_done_q <= fr_rsp.done;
        end
    end
    assign fr_value = fr_rsp.value;

    assign code_bad = (fr_value == '0) || (fr_value > {24'd0, code_count_reg});
    assign code_hit = (fr_value == {24'd0, scan_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_action != ACT_ADVANCE)
                    begin
                        state_next = S_OUT;
                    end
                    else if (((cur_reg == '0) && started_reg) || (in_char == 8'd0))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SORD_RD;
                    end
                end
            end
            S_SORD_RD:    state_next = S_SORD_CAP;
            S_SORD_CAP:   state_next = S_CHILD_REQ;
            S_CHILD_REQ:  state_next = S_CHILD_WAIT;
            S_CHILD_WAIT: if (fr_done_q) state_next = S_PROBE;
            S_PROBE:
            begin
                if ((jump_reg == '0) || probes_reg[PROBE_W-1])
                    state_next = S_OUT;
                else
                    state_next = S_CODE_REQ;
            end
            S_CODE_REQ:   state_next = S_CODE_WAIT;
            S_CODE_WAIT:
            begin
                if (fr_done_q)
                begin
                    if (code_bad || code_hit)
                        state_next = S_OUT;
                    else
                        state_next = S_CORD_RD;
                end
            end
            S_CORD_RD:    state_next = S_CORD_CAP;
            S_CORD_CAP:   state_next = (order_rdata < sord_reg) ? S_SIB_REQ : S_OUT;
            S_SIB_REQ:    state_next = S_SIB_WAIT;
            S_SIB_WAIT:   if (fr_done_q) state_next = S_PROBE;
            S_OUT:        if (m_tready) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = (state_reg == S_IDLE);
        m_tvalid     = (state_reg == S_OUT);
        m_tdata      = {6'd0, prev_reg, cur_reg, status_reg};
        fr_req.start = (state_reg == S_CHILD_REQ) || (state_reg == S_CODE_REQ)
                       || (state_reg == S_SIB_REQ);
        fr_req.node  = (state_reg == S_CHILD_REQ) ? cur_reg : idx_reg;
        case (state_reg)
            S_CHILD_REQ:
            begin
                fr_req.pos   = child_offset_reg;
                fr_req.width = child_bits_reg;
            end
            S_SIB_REQ:
            begin
                fr_req.pos   = {1'b0, code_bits_reg};
                fr_req.width = sibling_bits_reg;
            end
            default:
            begin
                fr_req.pos   = '0;
                fr_req.width = code_bits_reg;
            end
        endcase
        order_raddr = (state_reg == S_SORD_RD) ? (scan_reg - 8'd1) : (code_reg - 8'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            record_bits_reg  <= 7'd16;
            code_bits_reg    <= 5'd5;
            sibling_bits_reg <= 5'd5;
            child_offset_reg <= 6'd10;
            child_bits_reg   <= 5'd6;
            code_count_reg   <= 8'd0;
            trie_length_reg  <= 13'd0;
            cur_reg          <= '0;
            prev_reg         <= '0;
            started_reg      <= 1'b0;
            status_reg       <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_RECORD_BITS:  record_bits_reg  <= cfg_wdata[6:0];
                    REG_CODE_BITS:    code_bits_reg    <= cfg_wdata[4:0];
                    REG_SIBLING_BITS: sibling_bits_reg <= cfg_wdata[4:0];
                    REG_CHILD_OFFSET: child_offset_reg <= cfg_wdata[5:0];
                    REG_CHILD_BITS:   child_bits_reg   <= cfg_wdata[4:0];
                    REG_CODE_COUNT:   code_count_reg   <= cfg_wdata[7:0];
                    REG_TRIE_LENGTH:  trie_length_reg  <= cfg_wdata;
                    default:          ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= ST_DONE;
                        if (in_action == ACT_RESET_WALK)
                        begin
                            cur_reg     <= '0;
                            prev_reg    <= '0;
                            started_reg <= 1'b0;
                        end
                        else if (in_action == ACT_ADVANCE)
                        begin
                            status_reg <= ST_MISS;
                            if (!((cur_reg == '0) && started_reg))
                            begin
                                started_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_CODE_WAIT:
                begin
                    if (fr_done_q && !code_bad && code_hit)
                    begin
                        prev_reg   <= cur_reg;
                        cur_reg    <= idx_reg;
                        status_reg <= ST_PARTIAL;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                scan_reg   <= in_char;
                idx_reg    <= cur_reg;
                probes_reg <= '0;
            end
            S_SORD_CAP:   sord_reg <= order_rdata;
            S_CHILD_WAIT: if (fr_done_q) jump_reg <= fr_value;
            S_PROBE:      idx_reg <= idx_reg + jump_reg[NODE_BITS-1:0];
            S_CODE_WAIT:  if (fr_done_q) code_reg <= fr_value[7:0];
            S_SIB_WAIT:
            begin
                if (fr_done_q)
                begin
                    jump_reg   <= fr_value;
                    probes_reg <= probes_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- design/ptw_checker.sv -----
// Port-level checker for the trie walker, bound to the top level.
`include "packed_trie_walk_step_assert.svh"

module ptw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `PTW_ASSERT_NEXT(a_busy_after_take, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `PTW_ASSERT_NOW(a_one_in_flight, clk, rst_n, m_tvalid, !s_tready)
    `PTW_ASSERT_NOW(a_status_legal, clk, rst_n, m_tvalid, m_tdata[1:0] != 2'd3)
    `PTW_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))

endmodule

bind packed_trie_walk_step ptw_checker u_ptw_checker (.*);

// ----- verif/tb_top.sv -----
// Testbench for the packed trie walker: directed table, random walks, scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import ptw_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int NUM_PHASES  = 6;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] node;
        logic [15:0] prev;
    } walk_result_t;

    typedef struct {
        logic [1:0]   action;
        logic [11:0]  addr;
        logic [7:0]   data;
        logic [7:0]   chr;
        bit           typed;
        walk_result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [12:0] cfg_wdata;

    packed_trie_walk_step i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow state of the walker
    logic [7:0]   trie_mem [TRIE_BYTES];
    bit           trie_wr  [TRIE_BYTES];
    logic [7:0]   order_mem [ORDER_DEPTH];
    bit           order_wr  [ORDER_DEPTH];
    logic [15:0]  cur_node;
    logic [15:0]  prev_node;
    bit           walk_started;
    bit           touch_unwritten;
    longint unsigned cfg_val [7];

    walk_result_t expected_q [$];
    int           error_count = 0;
    int           beats_out = 0;
    longint       cycle_count = 0;
    int           burst_left;

    // record, code, sibling, child offset, child width, code count, trie length
    int phase_cfg [NUM_PHASES][7] = '{
        '{16, 3,  4,  7,  5,   7,   64},
        '{ 8, 2,  2,  4,  4,   3,   32},
        '{64, 16, 24, 40, 24,  255, 4096},
        '{ 1, 1,  1,  0,  1,   0,   0},
        '{12, 4,  5,  9,  3,   15,  128},
        '{64, 5,  5,  63, 1,   31,  256}
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [7:0] trie_byte(longint unsigned a);
        if (a < cfg_val[REG_TRIE_LENGTH] && a < TRIE_BYTES)
        begin
            if (!trie_wr[a])
                touch_unwritten = 1'b1;
            return trie_mem[a];
        end
        return 8'd0;
    endfunction

    function automatic logic [7:0] order_rank(longint unsigned idx);
        if (idx < ORDER_DEPTH)
        begin
            if (!order_wr[idx])
                touch_unwritten = 1'b1;
            return order_mem[idx];
        end
        return 8'd0;
    endfunction

    // MSB-first bit field of a record, cut to 32 bits
    function automatic longint unsigned record_field(longint unsigned node,
                                                     longint unsigned pos,
                                                     longint unsigned width);
        longint unsigned bitp;
        longint unsigned addr;
        longint unsigned have;
        longint unsigned acc;
        bitp = node * cfg_val[REG_RECORD_BITS] + pos;
        addr = bitp >> 3;
        have = 8 - (bitp & 7);
        acc  = trie_byte(addr) & ((64'd1 << have) - 1);
        while (have < width)
        begin
            addr++;
            acc = (acc << 8) | trie_byte(addr);
            have += 8;
        end
        acc = acc >> (have - width);
        return acc & 64'hFFFF_FFFF;
    endfunction

    // Advance without touching state; hit_node is valid on a partial match
    function automatic logic [1:0] walk_advance(logic [7:0] chr,
                                                output logic [15:0] hit_node);
        longint unsigned idx;
        longint unsigned jump;
        longint unsigned code;
        hit_node = cur_node;
        if (cur_node == 16'd0 && walk_started)
            return ST_MISS;
        idx  = cur_node;
        jump = record_field(cur_node, cfg_val[REG_CHILD_OFFSET], cfg_val[REG_CHILD_BITS]);
        if (chr == 8'd0)
            return ST_MISS;
        for (int probe = 0; jump != 0 && probe < 256; probe++)
        begin
            idx  = (idx + jump) & 64'hFFFF;
            code = record_field(idx, 0, cfg_val[REG_CODE_BITS]);
            if (code == 0 || code > cfg_val[REG_CODE_COUNT])
                return ST_MISS;
            if (code == chr)
            begin
                hit_node = idx[15:0];
                return ST_PARTIAL;
            end
            if (order_rank(code - 1) < order_rank(chr - 1))
                jump = record_field(idx, cfg_val[REG_CODE_BITS], cfg_val[REG_SIBLING_BITS]);
            else
                return ST_MISS;
        end
        return ST_MISS;
    endfunction

    // Turn an advance that would read an unwritten byte into a walk reset
    function automatic void make_legal(ref stim_row_t row);
        logic [15:0] hit;
        if (row.action != ACT_ADVANCE)
            return;
        touch_unwritten = 1'b0;
        void'(walk_advance(row.chr, hit));
        if (touch_unwritten)
            row.action = ACT_RESET_WALK;
    endfunction

    function automatic walk_result_t step_model(stim_row_t row);
        walk_result_t res;
        logic [15:0]  hit;
        res.status = ST_DONE;
        case (row.action)
            ACT_LOAD_TRIE:
            begin
                trie_mem[row.addr] = row.data;
                trie_wr[row.addr]  = 1'b1;
            end
            ACT_LOAD_ORDER:
            begin
                if (row.addr < ORDER_DEPTH)
                begin
                    order_mem[row.addr] = row.data;
                    order_wr[row.addr]  = 1'b1;
                end
            end
            ACT_RESET_WALK:
            begin
                cur_node     = 16'd0;
                prev_node    = 16'd0;
                walk_started = 1'b0;
            end
            default:
            begin
                res.status = walk_advance(row.chr, hit);
                if (!(cur_node == 16'd0 && walk_started))
                    walk_started = 1'b1;
                if (res.status == ST_PARTIAL)
                begin
                    prev_node = cur_node;
                    cur_node  = hit;
                end
            end
        endcase
        res.node = cur_node;
        res.prev = prev_node;
        return res;
    endfunction

    task automatic send_beat(stim_row_t row);
        walk_result_t res;
        int           gap;
        make_legal(row);
        res = step_model(row);
        expected_q.push_back(row.typed ? row.want : res);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, row.chr, row.data, row.addr, row.action};
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(logic [2:0] idx, int value);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[12:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_val[idx] = value;
    endtask

    function automatic stim_row_t plain_row(logic [1:0] act, logic [11:0] addr,
                                            logic [7:0] data, logic [7:0] chr);
        stim_row_t row;
        row.action = act;
        row.addr   = addr;
        row.data   = data;
        row.chr    = chr;
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic [1:0] act, logic [11:0] addr,
                                            logic [7:0] data, logic [7:0] chr,
                                            logic [1:0] st);
        stim_row_t row;
        row = plain_row(act, addr, data, chr);
        row.typed  = 1'b1;
        row.want   = '{status: st, node: 16'd0, prev: 16'd0};
        return row;
    endfunction

    function automatic stim_row_t random_row(int len);
        stim_row_t row;
        int        pick;
        int        top;
        top  = (1 << cfg_val[REG_CODE_BITS]) - 1;
        if (top > 255)
            top = 255;
        if (cfg_val[REG_CODE_COUNT] < top)
            top = int'(cfg_val[REG_CODE_COUNT]);
        row  = plain_row(ACT_ADVANCE, 12'($urandom_range(0, 4095)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            if (top > 0 && $urandom_range(0, 4) != 0)
                row.chr = 8'($urandom_range(1, top));
        end
        else if (pick < 78)
            row.action = ACT_RESET_WALK;
        else if (pick < 90)
        begin
            row.action = ACT_LOAD_TRIE;
            if (len > 0 && $urandom_range(0, 3) != 0)
                row.addr = 12'($urandom_range(0, (len > 4096 ? 4096 : len) - 1));
        end
        else
        begin
            row.action = ACT_LOAD_ORDER;
            row.addr   = 12'($urandom_range(0, 511));
        end
        return row;
    endfunction

    // Result side: stall pattern, one long hold-off, scoreboard
    int stall_phase;
    int hold_left;
    bit hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t got;
        walk_result_t want;
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_phase <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{status: m_tdata[1:0], node: m_tdata[17:2], prev: m_tdata[33:18]};
                beats_out++;
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.node !== want.node)
                    begin
                        $error("node_index: expected %0d, actual %0d", want.node, got.node);
                        error_count++;
                    end
                    if (got.prev !== want.prev)
                    begin
                        $error("prev_node: expected %0d, actual %0d", want.prev, got.prev);
                        error_count++;
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            if (!hold_done && beats_out == 500)
            begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_tready  <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if ((stall_phase / 64) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= (stall_phase % 5 != 0) && ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        stim_row_t directed [$];
        int        len;
        int        wait_cycles;
        burst_left  = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        cur_node    = '0;
        prev_node   = '0;
        walk_started = 1'b0;
        foreach (trie_wr[i])
            trie_wr[i] = 1'b0;
        foreach (order_wr[i])
            order_wr[i] = 1'b0;
        foreach (cfg_val[i])
            cfg_val[i] = 0;
        cfg_val[REG_RECORD_BITS]  = 16;
        cfg_val[REG_CODE_BITS]    = 5;
        cfg_val[REG_SIBLING_BITS] = 5;
        cfg_val[REG_CHILD_OFFSET] = 10;
        cfg_val[REG_CHILD_BITS]   = 6;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: trie length 0, so every field reads as zero
        directed.push_back(typed_row(ACT_LOAD_ORDER, 12'd0, 8'd0, 8'd0, ST_DONE));
        directed.push_back(typed_row(ACT_LOAD_ORDER, 12'd4095, 8'hFF, 8'hFF, ST_DONE));
        directed.push_back(typed_row(ACT_LOAD_ORDER, 12'd256, 8'h5A, 8'd1, ST_DONE));
        directed.push_back(typed_row(ACT_LOAD_TRIE, 12'd4095, 8'hFF, 8'd0, ST_DONE));
        directed.push_back(typed_row(ACT_LOAD_TRIE, 12'd0, 8'h00, 8'd0, ST_DONE));
        directed.push_back(typed_row(ACT_ADVANCE, 12'd0, 8'd0, 8'd0, ST_MISS));
        directed.push_back(typed_row(ACT_ADVANCE, 12'hABC, 8'd0, 8'd5, ST_MISS));
        directed.push_back(typed_row(ACT_RESET_WALK, 12'd0, 8'd0, 8'd0, ST_DONE));
        directed.push_back(typed_row(ACT_ADVANCE, 12'd0, 8'd0, 8'd255, ST_MISS));
        directed.push_back(typed_row(ACT_RESET_WALK, 12'hFFF, 8'hFF, 8'hFF, ST_DONE));
        directed.push_back(typed_row(ACT_ADVANCE, 12'd0, 8'd0, 8'd128, ST_MISS));
        directed.push_back(typed_row(ACT_RESET_WALK, 12'd0, 8'd0, 8'd0, ST_DONE));
        foreach (directed[i])
            send_beat(directed[i]);

        // Ascending rank table so sibling walks go on
        for (int i = 0; i < ORDER_DEPTH; i++)
            send_beat(plain_row(ACT_LOAD_ORDER, 12'(i), 8'(i), 8'd0));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            for (int r = 0; r < 7; r++)
                write_reg(3'(r), phase_cfg[ph][r]);
            len = phase_cfg[ph][6];
            for (int a = 0; a < len && a < 128; a++)
                send_beat(plain_row(ACT_LOAD_TRIE, 12'(a), 8'($urandom_range(0, 255)),
                                    8'd0));
            send_beat(plain_row(ACT_RESET_WALK, 12'd0, 8'd0, 8'd0));
            for (int n = 0; n < 100; n++)
                send_beat(random_row(len));
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (expected_q.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $error("%0d results never arrived", expected_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
